@@ hdl/subtractive_lagged_fibonacci_rng_unit_assert.svh @@
// Assertion macros used by the checker file of the random number unit.
`ifndef SUBTRACTIVE_LAGGED_FIBONACCI_RNG_UNIT_ASSERT_SVH
`define SUBTRACTIVE_LAGGED_FIBONACCI_RNG_UNIT_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define SLFRNG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define SLFRNG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hdl/slfrng_pkg.sv @@
// Shared constants, types and a helper function of the lagged-Fibonacci generator.
package slfrng_pkg;

	localparam int unsigned RING_LEN       = 55;
	localparam int unsigned RING_W         = 30;
	localparam int unsigned MOD_W          = RING_W + 1;
	localparam int unsigned MODULUS_DEF    = 1000000000;
	localparam int unsigned TRAIL_START    = 24;
	localparam int unsigned LEAD_TAP       = RING_LEN - 1;
	localparam int unsigned TRAIL_TAP      = TRAIL_START - 1;
	localparam int unsigned SCATTER_STRIDE = 21;
	localparam int unsigned SCATTER_SLOT   = RING_LEN - SCATTER_STRIDE;
	localparam int unsigned WARMUP_DRAWS   = 165;
	localparam int unsigned CNT_W          = $clog2(WARMUP_DRAWS);
	localparam int unsigned DATA_W         = 32;
	localparam int unsigned SPAN_W         = DATA_W + 1;
	localparam int unsigned DIV_CNT_W      = $clog2(RING_W + 1);
	localparam int unsigned FUNC_W         = 2;

	localparam logic [RING_W-1:0] RESET_SEED = RING_W'(999);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_RAW    = 2'd0,
		FUNC_RANGE  = 2'd1,
		FUNC_RESEED = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_SCATTER
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_SEED_DIV,
		ST_SCATTER,
		ST_WARM,
		ST_IDLE,
		ST_DRAW,
		ST_RANGE_DIV,
		ST_EMIT
	} state_t;

	function automatic logic [RING_W-1:0] sub_mod(
		input logic [RING_W-1:0] x,
		input logic [RING_W-1:0] y,
		input logic [MOD_W-1:0]  m
	);
		logic [MOD_W-1:0] sum;
		sum = (x >= y) ? MOD_W'(x) : (MOD_W'(x) + m);
		return RING_W'(sum - MOD_W'(y));
	endfunction

endpackage

@@ hdl/slfrng_cell.sv @@
// One residue cell of the lag ring: holds, shifts from its neighbor or takes the scatter input.
module slfrng_cell (
	input  logic                             clk,
	input  slfrng_pkg::cell_op_t             op,
	input  logic [slfrng_pkg::RING_W-1:0]    shift_d,
	input  logic [slfrng_pkg::RING_W-1:0]    scatter_d,
	output logic [slfrng_pkg::RING_W-1:0]    value_q
);

	always_ff @(posedge clk) begin
		unique case (op)
			slfrng_pkg::CELL_SHIFT: begin
				value_q <= shift_d;
			end
			slfrng_pkg::CELL_SCATTER: begin
				value_q <= scatter_d;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

@@ hdl/slfrng_rem_div.sv @@
// Radix-2 restoring remainder unit, one dividend bit per cycle.
module slfrng_rem_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [slfrng_pkg::RING_W-1:0]    dividend,
	input  logic [slfrng_pkg::SPAN_W-1:0]    divisor,
	output logic                             done_q,
	output logic [slfrng_pkg::SPAN_W-1:0]    rem_q
);

	logic [slfrng_pkg::RING_W-1:0]    dvd_q;
	logic [slfrng_pkg::SPAN_W-1:0]    dvs_q;
	logic [slfrng_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                             busy_q;
	logic [slfrng_pkg::SPAN_W:0]      trial;
	logic                             fits;

	assign trial = {rem_q, dvd_q[slfrng_pkg::RING_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= slfrng_pkg::DIV_CNT_W'(slfrng_pkg::RING_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - slfrng_pkg::DIV_CNT_W'(1);
				if (cnt_q == slfrng_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? slfrng_pkg::SPAN_W'(trial - {1'b0, dvs_q})
			              : slfrng_pkg::SPAN_W'(trial);
			dvd_q <= {dvd_q[slfrng_pkg::RING_W-2:0], 1'b0};
		end
	end

endmodule

@@ hdl/subtractive_lagged_fibonacci_rng_unit.sv @@
// Top level of the subtractive lagged-Fibonacci random number unit (lags 55 and 24).
// The 55 residues sit in a row of cells that shifts by one place per draw, the draw
// entering at the head; one item is worked at a time. A raw draw (func 0) passes from
// the accepting beat through the DRAW and EMIT states to the output. A ranged draw
// (func 1) passes through DRAW, RANGE_DIV and EMIT, where the radix-2 remainder unit
// (30 iterations) folds the draw into the span. Equal bounds return the upper bound
// with no draw. A reseed (func 2) reduces the seed register by the modulus in the same
// remainder unit, scatters it over the ring and runs 165 warm-up draws before its result
// shows. After reset the unit seeds itself from the reset seed and holds s_tready low
// until the warm-up ends. A finished result that finds the previous one still waiting on the
// output holds until m_tready frees it. An input beat is taken while a finished result
// still waits on the output.
module subtractive_lagged_fibonacci_rng_unit #(
	parameter int unsigned MODULUS = slfrng_pkg::MODULUS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               seed_value_we,
	input  logic [slfrng_pkg::RING_W-1:0]      seed_value_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [2*slfrng_pkg::DATA_W-1:0]    s_tdata,   // range_low, range_high
	input  logic [slfrng_pkg::FUNC_W-1:0]      s_tuser,   // func
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [slfrng_pkg::DATA_W-1:0]      m_tdata    // value
);

	localparam logic [slfrng_pkg::MOD_W-1:0]  MOD_V    = slfrng_pkg::MOD_W'(MODULUS);
	localparam logic [slfrng_pkg::SPAN_W-1:0] MOD_SPAN = slfrng_pkg::SPAN_W'(MODULUS);

	slfrng_pkg::state_t                  state_q;
	slfrng_pkg::state_t                  state_d;
	slfrng_pkg::cell_op_t                cell_op;
	logic [slfrng_pkg::RING_W-1:0]       cell_val [slfrng_pkg::RING_LEN];
	logic [slfrng_pkg::RING_W-1:0]       draw_val;
	logic [slfrng_pkg::RING_W-1:0]       seed_q;
	logic [slfrng_pkg::RING_W-1:0]       gen_a_q;
	logic [slfrng_pkg::RING_W-1:0]       gen_b_q;
	logic [slfrng_pkg::CNT_W-1:0]        cnt_q;
	logic                                reply_q;
	logic [slfrng_pkg::FUNC_W-1:0]       func_q;
	logic signed [slfrng_pkg::DATA_W-1:0] lo_q;
	logic signed [slfrng_pkg::DATA_W-1:0] hi_q;
	logic signed [slfrng_pkg::DATA_W-1:0] in_low;
	logic signed [slfrng_pkg::DATA_W-1:0] in_high;
	logic [slfrng_pkg::SPAN_W-1:0]       span;
	logic [slfrng_pkg::DATA_W-1:0]       res_q;
	logic [slfrng_pkg::DATA_W-1:0]       out_q;
	logic                                out_valid_q;
	logic                                accept;
	logic                                emit;
	logic                                div_start;
	logic [slfrng_pkg::RING_W-1:0]       div_dividend;
	logic [slfrng_pkg::SPAN_W-1:0]       div_divisor;
	logic                                div_done;
	logic [slfrng_pkg::SPAN_W-1:0]       div_rem;

	assign in_low   = s_tdata[slfrng_pkg::DATA_W-1:0];
	assign in_high  = s_tdata[2*slfrng_pkg::DATA_W-1:slfrng_pkg::DATA_W];
	assign accept   = s_tvalid && s_tready;
	assign emit     = (state_q == slfrng_pkg::ST_EMIT) && (!out_valid_q || m_tready);
	assign draw_val = slfrng_pkg::sub_mod(cell_val[slfrng_pkg::LEAD_TAP],
		cell_val[slfrng_pkg::TRAIL_TAP], MOD_V);
	assign span     = {hi_q[slfrng_pkg::DATA_W-1], hi_q} - {lo_q[slfrng_pkg::DATA_W-1], lo_q}
		+ slfrng_pkg::SPAN_W'(1);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	for (genvar i = 0; i < slfrng_pkg::RING_LEN; i++) begin : g_cell
		logic [slfrng_pkg::RING_W-1:0] shift_d;
		logic [slfrng_pkg::RING_W-1:0] scatter_d;

		if (i == 0) begin : g_head
			assign shift_d = draw_val;
		end else begin : g_body
			assign shift_d = cell_val[i-1];
		end

		if (i == slfrng_pkg::SCATTER_SLOT) begin : g_slot
			assign scatter_d = gen_a_q;
		end else begin : g_hop
			assign scatter_d = cell_val[(i + slfrng_pkg::SCATTER_STRIDE) % slfrng_pkg::RING_LEN];
		end

		slfrng_cell u_cell (
			.clk       (clk),
			.op        (cell_op),
			.shift_d   (shift_d),
			.scatter_d (scatter_d),
			.value_q   (cell_val[i])
		);
	end

	slfrng_rem_div u_rem_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done_q   (div_done),
		.rem_q    (div_rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slfrng_pkg::ST_INIT: begin
				state_d = slfrng_pkg::ST_SEED_DIV;
			end
			slfrng_pkg::ST_SEED_DIV: begin
				if (div_done) begin
					state_d = slfrng_pkg::ST_SCATTER;
				end
			end
			slfrng_pkg::ST_SCATTER: begin
				if (cnt_q == slfrng_pkg::CNT_W'(slfrng_pkg::RING_LEN - 1)) begin
					state_d = slfrng_pkg::ST_WARM;
				end
			end
			slfrng_pkg::ST_WARM: begin
				if (cnt_q == slfrng_pkg::CNT_W'(slfrng_pkg::WARMUP_DRAWS - 1)) begin
					state_d = reply_q ? slfrng_pkg::ST_EMIT : slfrng_pkg::ST_IDLE;
				end
			end
			slfrng_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						slfrng_pkg::FUNC_RAW: begin
							state_d = slfrng_pkg::ST_DRAW;
						end
						slfrng_pkg::FUNC_RANGE: begin
							state_d = (in_low == in_high) ? slfrng_pkg::ST_EMIT
							                              : slfrng_pkg::ST_DRAW;
						end
						slfrng_pkg::FUNC_RESEED: begin
							state_d = slfrng_pkg::ST_INIT;
						end
						default: begin
							state_d = slfrng_pkg::ST_EMIT;
						end
					endcase
				end
			end
			slfrng_pkg::ST_DRAW: begin
				state_d = (func_q == slfrng_pkg::FUNC_RAW) ? slfrng_pkg::ST_EMIT
				                                           : slfrng_pkg::ST_RANGE_DIV;
			end
			slfrng_pkg::ST_RANGE_DIV: begin
				if (div_done) begin
					state_d = slfrng_pkg::ST_EMIT;
				end
			end
			slfrng_pkg::ST_EMIT: begin
				if (!out_valid_q || m_tready) begin
					state_d = slfrng_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cell_op      = slfrng_pkg::CELL_HOLD;
		div_start    = 1'b0;
		div_dividend = seed_q;
		div_divisor  = MOD_SPAN;
		unique case (state_q)
			slfrng_pkg::ST_INIT: begin
				div_start = 1'b1;
			end
			slfrng_pkg::ST_SCATTER: begin
				cell_op = slfrng_pkg::CELL_SCATTER;
			end
			slfrng_pkg::ST_WARM: begin
				cell_op = slfrng_pkg::CELL_SHIFT;
			end
			slfrng_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			slfrng_pkg::ST_DRAW: begin
				cell_op      = slfrng_pkg::CELL_SHIFT;
				div_start    = (func_q != slfrng_pkg::FUNC_RAW);
				div_dividend = draw_val;
				div_divisor  = span;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slfrng_pkg::ST_INIT;
			cnt_q       <= '0;
			reply_q     <= 1'b0;
			out_valid_q <= 1'b0;
			seed_q      <= slfrng_pkg::RESET_SEED;
		end else begin
			state_q <= state_d;
			if ((state_d == state_q) && ((state_q == slfrng_pkg::ST_SCATTER) ||
				(state_q == slfrng_pkg::ST_WARM))) begin
				cnt_q <= cnt_q + slfrng_pkg::CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (accept) begin
				reply_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (seed_value_we) begin
				seed_q <= seed_value_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == slfrng_pkg::ST_SEED_DIV) && div_done) begin
			gen_a_q <= div_rem[slfrng_pkg::RING_W-1:0];
			gen_b_q <= slfrng_pkg::RING_W'(1);
		end else if (state_q == slfrng_pkg::ST_SCATTER) begin
			gen_a_q <= gen_b_q;
			gen_b_q <= slfrng_pkg::sub_mod(gen_a_q, gen_b_q, MOD_V);
		end
		if (accept) begin
			func_q <= s_tuser;
			if (in_low > in_high) begin
				lo_q <= in_high;
				hi_q <= in_low;
			end else begin
				lo_q <= in_low;
				hi_q <= in_high;
			end
			res_q <= (s_tuser == slfrng_pkg::FUNC_RANGE) ? in_high : '0;
		end else if ((state_q == slfrng_pkg::ST_DRAW) && (func_q == slfrng_pkg::FUNC_RAW)) begin
			res_q <= slfrng_pkg::DATA_W'(draw_val);
		end else if ((state_q == slfrng_pkg::ST_RANGE_DIV) && div_done) begin
			res_q <= div_rem[slfrng_pkg::DATA_W-1:0] + lo_q;
		end
		if (emit) begin
			out_q <= res_q;
		end
	end

endmodule

@@ hdl/slfrng_checker.sv @@
// Port-level checker for the random number unit, bound to the top level.
`include "subtractive_lagged_fibonacci_rng_unit_assert.svh"

module slfrng_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [slfrng_pkg::DATA_W-1:0]    m_tdata
);

	`SLFRNG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
	`SLFRNG_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input taken again before the previous beat finished")
	`SLFRNG_ASSERT_NOW(a_emit_frees_input, $rose(m_tvalid), s_tready, "result shown without returning to idle")

endmodule

bind subtractive_lagged_fibonacci_rng_unit slfrng_checker u_slfrng_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
